// ----- rtl/core/vn_pkg.sv -----
// Shared constants for the 3D vector normalizer.
`default_nettype none
package vn_pkg;
    localparam int COMP_W_DEF = 32;  // default component width
    localparam int NCOMP      = 3;   // components per vector
    localparam int QBITS      = 30;  // fraction bits of a unit component
    localparam int OUT_W      = 32;  // width of unit and magnitude fields
endpackage
`default_nettype wire

// ----- rtl/core/vn_square.sv -----
// Sign split and pipelined sum of squares of the three components.
`default_nettype none
module vn_square #(
    parameter int W = vn_pkg::COMP_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [W-1:0]         i_comp [vn_pkg::NCOMP],
    input  logic                 i_pt,
    output logic                 o_valid,
    output logic [W-1:0]         o_mag [vn_pkg::NCOMP],
    output logic [vn_pkg::NCOMP-1:0] o_neg,
    output logic                 o_pt,
    output logic [2*W:0]         o_sum
);
    import vn_pkg::*;

    localparam int H  = W / 2;
    localparam int HW = W - H;
    localparam int SW = 2 * W + 1;

    // stage 1: sign and magnitude
    logic             r_v1, r_pt1;
    logic [W-1:0]     r_mag1 [NCOMP];
    logic [NCOMP-1:0] r_neg1;
    // stage 2: partial products
    logic             r_v2, r_pt2;
    logic [W-1:0]     r_mag2 [NCOMP];
    logic [NCOMP-1:0] r_neg2;
    logic [2*HW-1:0]  r_hh [NCOMP];
    logic [HW+H-1:0]  r_hl [NCOMP];
    logic [2*H-1:0]   r_ll [NCOMP];
    // stage 3: squares
    logic             r_v3, r_pt3;
    logic [W-1:0]     r_mag3 [NCOMP];
    logic [NCOMP-1:0] r_neg3;
    logic [SW-1:0]    r_sq [NCOMP];
    // stage 4: sum
    logic             r_v4, r_pt4;
    logic [W-1:0]     r_mag4 [NCOMP];
    logic [NCOMP-1:0] r_neg4;
    logic [SW-1:0]    r_sum4;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt1  <= i_pt;
            r_pt2  <= r_pt1;
            r_pt3  <= r_pt2;
            r_pt4  <= r_pt3;
            r_neg2 <= r_neg1;
            r_neg3 <= r_neg2;
            r_neg4 <= r_neg3;
            for (int c = 0; c < NCOMP; c++) begin
                r_neg1[c] <= i_comp[c][W-1];
                r_mag1[c] <= i_comp[c][W-1] ? (W'(0) - i_comp[c]) : i_comp[c];
                r_mag2[c] <= r_mag1[c];
                r_mag3[c] <= r_mag2[c];
                r_mag4[c] <= r_mag3[c];
                r_hh[c]   <= (2*HW)'(r_mag1[c][W-1:H]) * (2*HW)'(r_mag1[c][W-1:H]);
                r_hl[c]   <= (HW+H)'(r_mag1[c][W-1:H]) * (HW+H)'(r_mag1[c][H-1:0]);
                r_ll[c]   <= (2*H)'(r_mag1[c][H-1:0]) * (2*H)'(r_mag1[c][H-1:0]);
                r_sq[c]   <= (SW'(r_hh[c]) << (2*H)) + (SW'(r_hl[c]) << (H+1))
                             + SW'(r_ll[c]);
            end
            r_sum4 <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_valid = r_v4;
    assign o_pt    = r_pt4;
    assign o_neg   = r_neg4;
    assign o_sum   = r_sum4;
    assign o_mag   = r_mag4;
endmodule
`default_nettype wire

// ----- rtl/core/vn_sqrt.sv -----
// Floor square root, one root bit per pipeline stage.
`default_nettype none
module vn_sqrt #(
    parameter int W = vn_pkg::COMP_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [W-1:0]         i_mag [vn_pkg::NCOMP],
    input  logic [vn_pkg::NCOMP-1:0] i_neg,
    input  logic                 i_pt,
    input  logic [2*W:0]         i_sum,
    output logic                 o_valid,
    output logic [W-1:0]         o_mag [vn_pkg::NCOMP],
    output logic [vn_pkg::NCOMP-1:0] o_neg,
    output logic                 o_pt,
    output logic [W-1:0]         o_root
);
    import vn_pkg::*;

    localparam int SW = 2 * W + 1;

    logic             r_v    [W];
    logic             r_pt   [W];
    logic [NCOMP-1:0] r_neg  [W];
    logic [W-1:0]     r_mag  [W][NCOMP];
    logic [SW-1:0]    r_rem  [W];
    logic [W-1:0]     r_root [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        localparam int B = W - 1 - k;
        logic             w_v, w_pt;
        logic [NCOMP-1:0] w_neg;
        logic [W-1:0]     w_mag [NCOMP];
        logic [SW-1:0]    w_rem, w_trial;
        logic [W-1:0]     w_root;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_pt   = i_pt;
            assign w_neg  = i_neg;
            assign w_mag  = i_mag;
            assign w_rem  = i_sum;
            assign w_root = '0;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_pt   = r_pt[k-1];
            assign w_neg  = r_neg[k-1];
            assign w_mag  = r_mag[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        // try setting root bit B: needs rem >= 2*root*2^B + 4^B
        assign w_trial = (SW'(w_root) << (B + 1)) | (SW'(1) << (2 * B));
        assign w_ge    = w_rem >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pt[k]  <= w_pt;
                r_neg[k] <= w_neg;
                r_mag[k] <= w_mag;
                r_rem[k] <= w_ge ? (w_rem - w_trial) : w_rem;
                r_root[k] <= w_ge ? (w_root | (W'(1) << B)) : w_root;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_pt    = r_pt[W-1];
    assign o_neg   = r_neg[W-1];
    assign o_mag   = r_mag[W-1];
    assign o_root  = r_root[W-1];
endmodule
`default_nettype wire

// ----- rtl/core/vn_divide.sv -----
// Restoring divider lanes, one quotient bit per stage for all three components.
`default_nettype none
module vn_divide #(
    parameter int W = vn_pkg::COMP_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [W-1:0]         i_mag [vn_pkg::NCOMP],
    input  logic [vn_pkg::NCOMP-1:0] i_neg,
    input  logic                 i_pt,
    input  logic [W-1:0]         i_len,
    output logic                 o_valid,
    output logic [vn_pkg::QBITS-1:0] o_quot [vn_pkg::NCOMP],
    output logic [vn_pkg::NCOMP-1:0] o_full,
    output logic [vn_pkg::NCOMP-1:0] o_neg,
    output logic                 o_pt,
    output logic [W-1:0]         o_len
);
    import vn_pkg::*;

    logic             r_v    [QBITS];
    logic             r_pt   [QBITS];
    logic [NCOMP-1:0] r_neg  [QBITS];
    logic [NCOMP-1:0] r_full [QBITS];
    logic [W-1:0]     r_len  [QBITS];
    logic [W:0]       r_rem  [QBITS][NCOMP];
    logic [QBITS-1:0] r_q    [QBITS][NCOMP];

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        logic             w_v, w_pt;
        logic [NCOMP-1:0] w_neg, w_full;
        logic [W-1:0]     w_len;
        logic [W:0]       w_rem [NCOMP];
        logic [QBITS-1:0] w_q   [NCOMP];

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_pt  = i_pt;
            assign w_neg = i_neg;
            assign w_len = i_len;
            for (genvar c = 0; c < NCOMP; c++) begin : g_in
                // magnitude equal to length gives exactly one
                assign w_full[c] = i_mag[c] >= i_len;
                assign w_rem[c]  = {1'b0, i_mag[c]};
                assign w_q[c]    = '0;
            end
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_pt   = r_pt[k-1];
            assign w_neg  = r_neg[k-1];
            assign w_full = r_full[k-1];
            assign w_len  = r_len[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_q    = r_q[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        // shift, compare, subtract per lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pt[k]   <= w_pt;
                r_neg[k]  <= w_neg;
                r_full[k] <= w_full;
                r_len[k]  <= w_len;
                for (int c = 0; c < NCOMP; c++) begin
                    if ({w_rem[c][W-1:0], 1'b0} >= {1'b0, w_len}) begin
                        r_rem[k][c] <= {w_rem[c][W-1:0], 1'b0} - {1'b0, w_len};
                        r_q[k][c]   <= {w_q[c][QBITS-2:0], 1'b1};
                    end else begin
                        r_rem[k][c] <= {w_rem[c][W-1:0], 1'b0};
                        r_q[k][c]   <= {w_q[c][QBITS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_v[QBITS-1];
    assign o_pt    = r_pt[QBITS-1];
    assign o_neg   = r_neg[QBITS-1];
    assign o_full  = r_full[QBITS-1];
    assign o_len   = r_len[QBITS-1];
    assign o_quot  = r_q[QBITS-1];
endmodule
`default_nettype wire

// ----- rtl/core/vector3_normalise.sv -----
// Top level of the pipelined 3D vector normalizer.
`default_nettype none
// Takes one vector of three signed Q16.16 components per item and returns its
// floor-root length (unsigned Q16.16, saturated to 32 bits) and each component
// divided by that length as signed Q2.30, truncated toward zero. A zero vector
// gives zero_length = 1 with zero length and zero unit components. The flag
// is_point passes through. One item is accepted every cycle unless the
// pipeline holds; there are 4 square/sum stages, one stage per root bit,
// 30 divider stages and one output stage. The whole pipeline holds while a
// result waits and the output is not taken.
module vector3_normalise #(
    parameter int COMPONENT_WIDTH = vn_pkg::COMP_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [COMPONENT_WIDTH-1:0] i_comp_x,
    input  logic [COMPONENT_WIDTH-1:0] i_comp_y,
    input  logic [COMPONENT_WIDTH-1:0] i_comp_z,
    input  logic                       i_is_point,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [vn_pkg::OUT_W-1:0]   o_unit_x,
    output logic [vn_pkg::OUT_W-1:0]   o_unit_y,
    output logic [vn_pkg::OUT_W-1:0]   o_unit_z,
    output logic [vn_pkg::OUT_W-1:0]   o_magnitude,
    output logic                       o_is_point_out,
    output logic                       o_zero_length
);
    import vn_pkg::*;

    localparam int W  = COMPONENT_WIDTH;
    localparam int MW = (W > OUT_W) ? W : OUT_W;

    logic             w_en;
    logic [W-1:0]     w_comp [NCOMP];

    logic             sq_v, sq_pt;
    logic [W-1:0]     sq_mag [NCOMP];
    logic [NCOMP-1:0] sq_neg;
    logic [2*W:0]     sq_sum;

    logic             rt_v, rt_pt;
    logic [W-1:0]     rt_mag [NCOMP];
    logic [NCOMP-1:0] rt_neg;
    logic [W-1:0]     rt_root;

    logic             dv_v, dv_pt;
    logic [QBITS-1:0] dv_q [NCOMP];
    logic [NCOMP-1:0] dv_full, dv_neg;
    logic [W-1:0]     dv_len;

    logic             r_out_valid, r_pt, r_zero;
    logic [OUT_W-1:0] r_unit [NCOMP];
    logic [OUT_W-1:0] r_mag;
    logic [OUT_W-1:0] n_unit [NCOMP];
    logic [OUT_W-1:0] n_mag;
    logic [MW-1:0]    w_len_ext;

    // pipeline advances unless a result is held
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_comp[0] = i_comp_x;
    assign w_comp[1] = i_comp_y;
    assign w_comp[2] = i_comp_z;

    vn_square #(.W(W)) u_square (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_in_valid), .i_comp(w_comp), .i_pt(i_is_point),
        .o_valid(sq_v), .o_mag(sq_mag), .o_neg(sq_neg), .o_pt(sq_pt), .o_sum(sq_sum)
    );

    vn_sqrt #(.W(W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(sq_v), .i_mag(sq_mag), .i_neg(sq_neg), .i_pt(sq_pt), .i_sum(sq_sum),
        .o_valid(rt_v), .o_mag(rt_mag), .o_neg(rt_neg), .o_pt(rt_pt), .o_root(rt_root)
    );

    vn_divide #(.W(W)) u_divide (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(rt_v), .i_mag(rt_mag), .i_neg(rt_neg), .i_pt(rt_pt), .i_len(rt_root),
        .o_valid(dv_v), .o_quot(dv_q), .o_full(dv_full), .o_neg(dv_neg),
        .o_pt(dv_pt), .o_len(dv_len)
    );

    // final sign, zero vector and saturation
    assign w_len_ext = MW'(dv_len);
    always_comb begin
        n_mag = (w_len_ext > MW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : w_len_ext[OUT_W-1:0];
        for (int c = 0; c < NCOMP; c++) begin
            n_unit[c] = dv_full[c] ? (OUT_W'(1) << QBITS) : OUT_W'(dv_q[c]);
            if (dv_neg[c]) begin
                n_unit[c] = OUT_W'(0) - n_unit[c];
            end
            if (dv_len == '0) begin
                n_unit[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_unit <= n_unit;
            r_mag  <= n_mag;
            r_pt   <= dv_pt;
            r_zero <= dv_len == '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_unit_x       = r_unit[0];
    assign o_unit_y       = r_unit[1];
    assign o_unit_z       = r_unit[2];
    assign o_magnitude    = r_mag;
    assign o_is_point_out = r_pt;
    assign o_zero_length  = r_zero;

`ifndef SYNTHESIS
    // zero vector gives zero length and zero unit components
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_length |->
            o_magnitude == '0 && o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0)
        else $error("zero vector result not all zero");

    // a nonzero length never reads as zero
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_zero_length |-> o_magnitude != '0)
        else $error("nonzero vector with zero magnitude");

    // unit components stay within plus or minus one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            $signed(o_unit_x) <= $signed(OUT_W'(1) << QBITS)
            && $signed(o_unit_x) >= -$signed(OUT_W'(1) << QBITS)
            && $signed(o_unit_y) <= $signed(OUT_W'(1) << QBITS)
            && $signed(o_unit_y) >= -$signed(OUT_W'(1) << QBITS)
            && $signed(o_unit_z) <= $signed(OUT_W'(1) << QBITS)
            && $signed(o_unit_z) >= -$signed(OUT_W'(1) << QBITS))
        else $error("unit component out of range");
`endif
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the 3D vector normalizer.
`timescale 1ns / 1ps
module tb_top;
    localparam int CW        = vn_pkg::COMP_W_DEF;
    localparam int LATENCY   = CW + 35;
    localparam int N_RANDOM  = 900;
    localparam int CYCLE_MAX = 200000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          pt;
    } t_vec;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic [31:0] mag;
        logic        pt;
        logic        zero;
    } t_unit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [CW-1:0] i_comp_x = '0, i_comp_y = '0, i_comp_z = '0;
    logic i_is_point = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [31:0] o_unit_x, o_unit_y, o_unit_z, o_magnitude;
    logic o_is_point_out, o_zero_length;

    vector3_normalise #(.COMPONENT_WIDTH(CW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_comp_x(i_comp_x), .i_comp_y(i_comp_y), .i_comp_z(i_comp_z),
        .i_is_point(i_is_point),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_unit_x(o_unit_x), .o_unit_y(o_unit_y), .o_unit_z(o_unit_z),
        .o_magnitude(o_magnitude), .o_is_point_out(o_is_point_out),
        .o_zero_length(o_zero_length)
    );

    t_vec  vec_queue[$];
    t_unit unit_expected[$];
    int    err_count = 0;
    int    n_checked = 0;
    int    n_zero = 0;
    int    cycle = 0;
    bit    fill_done = 0;
    bit    calm = 0;         // no idling in the last part of the run
    bit    hold_off = 0;     // long receiver stall
    bit    in_taken = 0;     // input item accepted at the last rising edge
    int    tx_gap = 0, rx_gap = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Magnitude of a component
    function automatic logic [CW:0] abs_comp(input logic [CW-1:0] v);
        return v[CW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    endfunction

    // Signed Q2.30 quotient trunc(m * 2^30 / len)
    function automatic logic [31:0] unit_of(input logic [CW:0] m, input logic neg,
                                            input logic [127:0] len);
        logic [127:0] q;
        q = ({m, 30'd0} >= (len << 30) - len + 1) && m >= len ? 128'd1 << 30
            : ({98'd0, m} << 30) / len;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    // Expected normalized vector for one input
    function automatic t_unit normalise(input t_vec v);
        t_unit r;
        logic [CW:0] mx, my, mz;
        logic [127:0] sum, root, cand;
        mx = abs_comp(v.x);
        my = abs_comp(v.y);
        mz = abs_comp(v.z);
        sum = 128'(mx) * mx + 128'(my) * my + 128'(mz) * mz;
        root = '0;
        for (int b = 48; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum) root = cand;
        end
        r.mag  = root > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : root[31:0];
        r.pt   = v.pt;
        r.zero = (root == 0);
        if (r.zero) begin
            r.ux = '0; r.uy = '0; r.uz = '0;
        end else begin
            r.ux = unit_of(mx, v.x[CW-1], root);
            r.uy = unit_of(my, v.y[CW-1], root);
            r.uz = unit_of(mz, v.z[CW-1], root);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("MISMATCH %s: got %h, want %h", what, got, want);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return CW'($urandom_range(0, 3)) - CW'(1);
            3: return CW'($signed(16'($urandom)));
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic push_vec(input logic [CW-1:0] x, y, z, input logic pt);
        t_vec v;
        v.x = x; v.y = y; v.z = z; v.pt = pt;
        vec_queue.push_back(v);
    endtask

    // Stimulus: directed corners, then random vectors
    initial begin
        logic [CW-1:0] mn, mx;
        mn = {1'b1, {(CW-1){1'b0}}};
        mx = {1'b0, {(CW-1){1'b1}}};
        push_vec('0, '0, '0, 1'b0);
        push_vec('0, '0, '0, 1'b1);
        push_vec(mn, mn, mn, 1'b1);
        push_vec(mx, mx, mx, 1'b0);
        push_vec(mn, '0, '0, 1'b0);
        push_vec('0, mx, '0, 1'b1);
        push_vec('0, '0, mn, 1'b0);
        push_vec(CW'(1), '0, '0, 1'b0);
        push_vec('1, '0, '0, 1'b1);
        push_vec(CW'(32'h0001_0000), CW'(32'h0001_0000), CW'(32'h0001_0000), 1'b0);
        push_vec(CW'(3), CW'(4), '0, 1'b1);
        push_vec(mx, mn, CW'(1), 1'b1);
        push_vec('1, '1, '1, 1'b0);
        push_vec(CW'(32'h5555_5555), CW'(32'hAAAA_AAAA), CW'(32'h0F0F_0F0F), 1'b1);
        for (int i = 0; i < N_RANDOM; i++)
            push_vec(rand_comp(), rand_comp(), rand_comp(), 1'($urandom));
        fill_done = 1;
    end

    // Reset, then long receiver stall, then calm tail
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (LATENCY * 3) @(posedge i_clk);
        hold_off = 0;
        wait (fill_done && vec_queue.size() < 150);
        calm = 1;
    end

    // Driver: falling-edge updates of the input channel
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // a waiting item stays until the rising edge that took it
            if (!i_in_valid || in_taken) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    tx_gap <= $urandom_range(0, 13);
                    i_in_valid <= 1'b0;
                end else if (vec_queue.size() > 0) begin
                    t_vec v;
                    v = vec_queue.pop_front();
                    i_comp_x <= v.x; i_comp_y <= v.y; i_comp_z <= v.z;
                    i_is_point <= v.pt;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rx_gap <= $urandom_range(0, 13);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            t_vec v;
            v.x = i_comp_x; v.y = i_comp_y; v.z = i_comp_z; v.pt = i_is_point;
            unit_expected.push_back(normalise(v));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (unit_expected.size() == 0) begin
                report_mismatch("unexpected item", 32'(o_magnitude), 32'd0);
            end else begin
                t_unit e;
                e = unit_expected.pop_front();
                n_checked <= n_checked + 1;
                if (e.zero) n_zero <= n_zero + 1;
                if (o_unit_x !== e.ux) report_mismatch("unit_x", o_unit_x, e.ux);
                if (o_unit_y !== e.uy) report_mismatch("unit_y", o_unit_y, e.uy);
                if (o_unit_z !== e.uz) report_mismatch("unit_z", o_unit_z, e.uz);
                if (o_magnitude !== e.mag)
                    report_mismatch("magnitude", o_magnitude, e.mag);
                if (o_is_point_out !== e.pt)
                    report_mismatch("is_point_out", 32'(o_is_point_out), 32'(e.pt));
                if (o_zero_length !== e.zero)
                    report_mismatch("zero_length", 32'(o_zero_length), 32'(e.zero));
            end
        end
    end

    // End of run and timeout
    initial begin
        fork
            begin
                wait (fill_done && vec_queue.size() == 0);
                @(posedge i_clk);
                wait (!i_in_valid && unit_expected.size() == 0);
                repeat (LATENCY + 10) @(posedge i_clk);
                if (unit_expected.size() != 0) err_count++;
                $display("Checked %0d vectors (%0d zero-length), incl. extremes", n_checked,
                         n_zero);
                $display("and a long output stall with the pipeline backed up.");
                if (err_count == 0)
                    $display("DONE: 0 errors");
                else
                    $display("DONE: errors detected");
            end
            begin
                wait (cycle >= CYCLE_MAX);
                $display("Timeout after %0d cycles", cycle);
                $display("DONE: errors detected");
            end
        join_any
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/vn_pkg.sv
rtl/core/vn_square.sv
rtl/core/vn_sqrt.sv
rtl/core/vn_divide.sv
rtl/core/vector3_normalise.sv
bench/tb_top.sv
